// ===== design/csf_pkg.sv =====
// Shared types, constants and the CRC step function of the CRC-16 byte-stuffed framer.
// Used by every module of the framer; depends on nothing else.
package csf_pkg;

	localparam int MAX_PAYLOAD = 1024;
	localparam int LEN_W = 11;
	localparam int FRAME_LEN_W = 12;
	localparam int CFG_INDEX_W = 2;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] START_BYTE_RST = 8'h7E;
	localparam logic [7:0] ESCAPE_BYTE_RST = 8'h7D;
	localparam logic [7:0] NODE_ADDR_RST = 8'h01;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_START_BYTE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_BYTE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_NODE_ADDR = 2'd2;

	// Input operation codes, also used as command kinds in the queue.
	localparam logic OP_START = 1'b0;
	localparam logic OP_PAYLOAD = 1'b1;

	typedef struct packed {
		logic             operation;
		logic [31:0]      flags;
		logic [15:0]      sequence_req;
		logic [LEN_W-1:0] payload_len;
		logic [7:0]       payload_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]             out_byte;
		logic                   run_last;
		logic                   frame_end;
		logic [15:0]            crc_value;
		logic [FRAME_LEN_W-1:0] frame_len;
	} out_item_t;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] escape_byte;
		logic [7:0] node_addr;
	} cfg_t;

	// One classified command from the front end to the byte sequencer.
	typedef struct packed {
		logic             kind;
		logic [31:0]      flags;
		logic [15:0]      sequence_req;
		logic [LEN_W-1:0] payload_len;
		logic [7:0]       payload_byte;
		logic             last;
	} cmd_t;

	// CRC-16/MODBUS update with one byte, LSB first.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== design/crc16_byte_stuffed_framer_core.sv =====
// Top level of the CRC-16 byte-stuffed framer: configuration registers, front end,
// command queue and byte sequencer. Depends on csf_pkg, csf_front, csf_queue and csf_back.
//
// Usage. A start item (operation 0) carries flags, sequence_req and payload_len and
// produces the frame header: the start byte unescaped, then the node address, flags,
// sequence and the clamped length, big-endian, each escaped when it equals the start
// or escape value. Payload items (operation 1) each produce one payload byte, and the
// last one is followed by the CRC-16/MODBUS, high byte first. With a zero length the
// CRC follows the header at once. Payload items with no frame open are dropped.
// Configuration writes go through cfg_valid/cfg_ready with cfg_index selecting
// start_byte, escape_byte or node_addr; cfg_ready is always high and writes are
// expected only while the framer is idle.
// The sequencer emits one wire byte per cycle while the output register is not stalled.
// Wire bytes per item: one or two for a payload byte, up to four more with the
// CRC, and 10 to 23 for a start item. The front end accepts one item per cycle as
// long as the two-entry command queue has room. An accepted item is first written
// into the queue; once it reaches the head, the sequencer loads its first wire byte
// into the output register. Reset clears the queue, the open-frame tracking and the
// output valid flag and loads the default configuration. When the receiver stalls,
// the output register holds its item, the sequencer waits, the queue fills and
// in_ready drops.
module crc16_byte_stuffed_framer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  csf_pkg::in_item_t               in_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output csf_pkg::out_item_t              out_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [csf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                      cfg_data
);

	csf_pkg::cfg_t cfg_q;
	csf_pkg::cmd_t push_cmd;
	csf_pkg::cmd_t head_cmd;
	logic          push;
	logic          queue_full;
	logic          head_valid;
	logic          cmd_pop;

	// The register file never stalls a write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte <= csf_pkg::START_BYTE_RST;
			cfg_q.escape_byte <= csf_pkg::ESCAPE_BYTE_RST;
			cfg_q.node_addr <= csf_pkg::NODE_ADDR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				csf_pkg::CFG_START_BYTE: cfg_q.start_byte <= cfg_data;
				csf_pkg::CFG_ESCAPE_BYTE: cfg_q.escape_byte <= cfg_data;
				csf_pkg::CFG_NODE_ADDR: cfg_q.node_addr <= cfg_data;
				// Writes to unlisted indexes are ignored.
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Classifies items and keeps track of how many payload bytes the open frame expects.
	csf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// Decouples item acceptance from byte emission.
	csf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (queue_full),
		.pop        (cmd_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// Emits one wire byte per cycle into the output register while the output is not stalled.
	csf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (head_valid),
		.cmd       (head_cmd),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ===== design/csf_front.sv =====
// Front end of the framer: accepts input items, clamps lengths, tracks open frames
// and drops stray payload bytes. Depends on csf_pkg.
module csf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  csf_pkg::in_item_t in_item,
	input  logic              queue_full,
	output logic              push,
	output csf_pkg::cmd_t     push_cmd
);

	logic [csf_pkg::LEN_W-1:0] remaining_q;
	logic [csf_pkg::LEN_W-1:0] len_clamped;
	logic                      accept;
	logic                      is_start;
	logic                      frame_live;

	assign in_ready = !queue_full;
	assign accept = in_valid && in_ready;
	assign is_start = (in_item.operation == csf_pkg::OP_START);
	assign frame_live = (remaining_q != '0);

	always_comb begin
		if (in_item.payload_len > csf_pkg::LEN_W'(csf_pkg::MAX_PAYLOAD)) begin
			len_clamped = csf_pkg::LEN_W'(csf_pkg::MAX_PAYLOAD);
		end else begin
			len_clamped = in_item.payload_len;
		end
	end

	assign push = accept && (is_start || frame_live);

	always_comb begin
		push_cmd.kind = in_item.operation;
		push_cmd.flags = in_item.flags;
		push_cmd.sequence_req = in_item.sequence_req;
		push_cmd.payload_len = len_clamped;
		push_cmd.payload_byte = in_item.payload_byte;
		push_cmd.last = (remaining_q == csf_pkg::LEN_W'(1));
	end

	// A frame is open exactly while payload bytes remain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
		end else if (accept) begin
			if (is_start) begin
				remaining_q <= len_clamped;
			end else if (frame_live) begin
				remaining_q <= remaining_q - csf_pkg::LEN_W'(1);
			end
		end
	end

endmodule

// ===== design/csf_queue.sv =====
// Two-entry command queue between the front end and the byte sequencer.
// Depends on csf_pkg for the command type and depth.
module csf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  csf_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output csf_pkg::cmd_t head_cmd
);

	localparam int PTR_W = (csf_pkg::QUEUE_DEPTH > 1) ? $clog2(csf_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(csf_pkg::QUEUE_DEPTH + 1);

	csf_pkg::cmd_t mem_q [csf_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full = (count_q == CNT_W'(csf_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(csf_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== design/csf_back.sv =====
// Byte sequencer of the framer: walks each command through its wire bytes, inserts
// escapes, updates the CRC and frame length, and drives the output register. Depends on csf_pkg.
module csf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  csf_pkg::cfg_t      cfg,
	input  logic               cmd_valid,
	input  csf_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output csf_pkg::out_item_t out_item
);

	localparam logic [3:0] ST_SOF  = 4'd0;
	localparam logic [3:0] ST_DEV  = 4'd1;
	localparam logic [3:0] ST_FL3  = 4'd2;
	localparam logic [3:0] ST_FL2  = 4'd3;
	localparam logic [3:0] ST_FL1  = 4'd4;
	localparam logic [3:0] ST_FL0  = 4'd5;
	localparam logic [3:0] ST_SQ1  = 4'd6;
	localparam logic [3:0] ST_SQ0  = 4'd7;
	localparam logic [3:0] ST_LN1  = 4'd8;
	localparam logic [3:0] ST_LN0  = 4'd9;
	localparam logic [3:0] ST_DATA = 4'd10;
	localparam logic [3:0] ST_CRCH = 4'd11;
	localparam logic [3:0] ST_CRCL = 4'd12;

	logic [3:0]                      step_q;
	logic                            fresh_q;
	logic                            esc_sent_q;
	logic [15:0]                     crc_q;
	logic [csf_pkg::FRAME_LEN_W-1:0] cnt_q;
	logic                            out_valid_q;
	csf_pkg::out_item_t              out_item_q;

	logic [3:0]                      step;
	logic [3:0]                      step_nx;
	logic                            cmd_done;
	logic [7:0]                      cur_byte;
	logic                            need_esc;
	logic                            feeds_crc;
	logic [15:0]                     crc_fed;
	logic [csf_pkg::FRAME_LEN_W-1:0] cnt_next;
	logic                            fire;
	logic                            frame_end;

	// A command that has just reached the head starts at its first step.
	always_comb begin
		if (fresh_q) begin
			step = (cmd.kind == csf_pkg::OP_START) ? ST_SOF : ST_DATA;
		end else begin
			step = step_q;
		end
	end

	always_comb begin
		cur_byte = 8'h00;
		step_nx = ST_SOF;
		cmd_done = 1'b1;
		unique case (step)
			ST_SOF: begin
				cur_byte = cfg.start_byte;
				step_nx = ST_DEV;
				cmd_done = 1'b0;
			end
			ST_DEV: begin
				cur_byte = cfg.node_addr;
				step_nx = ST_FL3;
				cmd_done = 1'b0;
			end
			ST_FL3: begin
				cur_byte = cmd.flags[31:24];
				step_nx = ST_FL2;
				cmd_done = 1'b0;
			end
			ST_FL2: begin
				cur_byte = cmd.flags[23:16];
				step_nx = ST_FL1;
				cmd_done = 1'b0;
			end
			ST_FL1: begin
				cur_byte = cmd.flags[15:8];
				step_nx = ST_FL0;
				cmd_done = 1'b0;
			end
			ST_FL0: begin
				cur_byte = cmd.flags[7:0];
				step_nx = ST_SQ1;
				cmd_done = 1'b0;
			end
			ST_SQ1: begin
				cur_byte = cmd.sequence_req[15:8];
				step_nx = ST_SQ0;
				cmd_done = 1'b0;
			end
			ST_SQ0: begin
				cur_byte = cmd.sequence_req[7:0];
				step_nx = ST_LN1;
				cmd_done = 1'b0;
			end
			ST_LN1: begin
				cur_byte = {5'd0, cmd.payload_len[10:8]};
				step_nx = ST_LN0;
				cmd_done = 1'b0;
			end
			ST_LN0: begin
				cur_byte = cmd.payload_len[7:0];
				step_nx = ST_CRCH;
				cmd_done = (cmd.payload_len != '0);
			end
			ST_DATA: begin
				cur_byte = cmd.payload_byte;
				step_nx = ST_CRCH;
				cmd_done = !cmd.last;
			end
			ST_CRCH: begin
				cur_byte = crc_q[15:8];
				step_nx = ST_CRCL;
				cmd_done = 1'b0;
			end
			ST_CRCL: begin
				cur_byte = crc_q[7:0];
				step_nx = ST_SOF;
				cmd_done = 1'b1;
			end
			default: begin
				cur_byte = 8'h00;
				step_nx = ST_SOF;
				cmd_done = 1'b1;
			end
		endcase
	end

	// The start byte is the only one never escaped.
	assign need_esc = (step != ST_SOF) && !esc_sent_q &&
		((cur_byte == cfg.start_byte) || (cur_byte == cfg.escape_byte));
	assign feeds_crc = (step <= ST_DATA);
	assign crc_fed = csf_pkg::crc_feed((step == ST_SOF) ? csf_pkg::CRC_INIT : crc_q, cur_byte);
	assign cnt_next = (step == ST_SOF) ? csf_pkg::FRAME_LEN_W'(1)
		: cnt_q + csf_pkg::FRAME_LEN_W'(1);
	assign fire = cmd_valid && (!out_valid_q || out_ready);
	assign cmd_pop = fire && !need_esc && cmd_done;
	assign frame_end = !need_esc && (step == ST_CRCL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_SOF;
			fresh_q <= 1'b1;
			esc_sent_q <= 1'b0;
			crc_q <= csf_pkg::CRC_INIT;
			cnt_q <= '0;
		end else if (fire) begin
			cnt_q <= cnt_next;
			if (need_esc) begin
				esc_sent_q <= 1'b1;
			end else begin
				esc_sent_q <= 1'b0;
				if (feeds_crc) begin
					crc_q <= crc_fed;
				end
				if (cmd_done) begin
					fresh_q <= 1'b1;
				end else begin
					fresh_q <= 1'b0;
					step_q <= step_nx;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_item_q.out_byte <= need_esc ? cfg.escape_byte : cur_byte;
			out_item_q.run_last <= !need_esc && cmd_done;
			out_item_q.frame_end <= frame_end;
			out_item_q.crc_value <= frame_end ? crc_q : 16'h0000;
			out_item_q.frame_len <= frame_end ? cnt_next : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

endmodule

// ===== design/csf_checker.sv =====
// Port-level checker for the CRC-16 byte-stuffed framer, bound to the top level.
// Depends on csf_pkg and crc16_byte_stuffed_framer_core.
module csf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input csf_pkg::out_item_t out_item
);

	// A stalled result item holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("output item changed while stalled");

	// The frame's final byte is always the last result of its item.
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.frame_end |-> out_item.run_last)
		else $error("frame_end without run_last");

	// CRC and length fields are zero away from the end of a frame.
	a_side_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.frame_end |->
			(out_item.crc_value == 16'h0000) && (out_item.frame_len == '0))
		else $error("crc_value or frame_len set before frame end");

	// A complete frame has at least the header and two CRC bytes.
	a_min_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.frame_end |-> (out_item.frame_len >= 12'd12))
		else $error("frame shorter than header plus CRC");

endmodule

bind crc16_byte_stuffed_framer_core csf_checker u_csf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
